### src/snt_pkg.sv
// Shared types, token codes and keyword tables for the set-notation token lexer.
`default_nettype none

package snt_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int MAX_FRAC_DIGITS   = 18;

    localparam logic [4:0] K_UNION   = 5'd0;
    localparam logic [4:0] K_INTER   = 5'd1;
    localparam logic [4:0] K_APPEND  = 5'd2;
    localparam logic [4:0] K_COMMA   = 5'd3;
    localparam logic [4:0] K_NULL    = 5'd4;
    localparam logic [4:0] K_EMPTY   = 5'd5;
    localparam logic [4:0] K_UNIV    = 5'd6;
    localparam logic [4:0] K_WILD    = 5'd7;
    localparam logic [4:0] K_LBRACK  = 5'd8;
    localparam logic [4:0] K_RBRACK  = 5'd9;
    localparam logic [4:0] K_LBRACE  = 5'd10;
    localparam logic [4:0] K_RBRACE  = 5'd11;
    localparam logic [4:0] K_COLON   = 5'd12;
    localparam logic [4:0] K_LPAREN  = 5'd13;
    localparam logic [4:0] K_RPAREN  = 5'd14;
    localparam logic [4:0] K_BANG    = 5'd15;
    localparam logic [4:0] K_TRUE    = 5'd16;
    localparam logic [4:0] K_FALSE   = 5'd17;
    localparam logic [4:0] K_NUMBER  = 5'd18;
    localparam logic [4:0] K_SBYTE   = 5'd19;
    localparam logic [4:0] K_SEND    = 5'd20;
    localparam logic [4:0] K_END     = 5'd21;
    localparam logic [4:0] K_ERROR   = 5'd22;

    typedef enum logic [2:0] {
        M_IDLE,
        M_NULL,
        M_TRUE,
        M_FALSE,
        M_WIDE,
        M_NUM,
        M_STR
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } tok_in_t;

    typedef struct packed {
        logic [4:0]         token_kind;
        logic signed [63:0] number_value;
        logic [7:0]         string_byte;
        logic               last_of_run;
    } tok_out_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_finish;
        logic send_adv;
    } snt_cmd_t;

    typedef struct packed {
        logic plan_div;
        logic plan_any;
        logic div_busy;
        logic send_last;
    } snt_sts_t;

    function automatic logic [7:0] kw_char(mode_t m, logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        unique case (m)
            M_NULL:
            begin
                case (p)
                    3'd1: c = 8'h75;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h6C;
                    default: c = 8'h00;
                endcase
            end
            M_TRUE:
            begin
                case (p)
                    3'd1: c = 8'h72;
                    3'd2: c = 8'h75;
                    3'd3: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            M_FALSE:
            begin
                case (p)
                    3'd1: c = 8'h61;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h73;
                    3'd4: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(mode_t m);
        return (m == M_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [4:0] kw_kind(mode_t m);
        logic [4:0] k;
        unique case (m)
            M_NULL:  k = K_NULL;
            M_TRUE:  k = K_TRUE;
            default: k = K_FALSE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### src/snt_datapath.sv
// Lexer datapath: token state, result slots and the divide-by-ten unit.
`default_nettype none

module snt_datapath #(
    parameter int FRACTION_BITS = snt_pkg::FRACTION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire snt_pkg::tok_in_t  in_data,
    input  wire snt_pkg::snt_cmd_t cmd,
    output snt_pkg::snt_sts_t      sts,
    output snt_pkg::tok_out_t      out_data
);
    import snt_pkg::*;

    localparam int ACC_W = 63 - FRACTION_BITS;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    typedef struct packed {
        logic zero;
        logic dig;
        logic dot;
        logic neg;
    } nflags_t;

    mode_t             mode_reg, mode_next;
    logic [2:0]        prog_reg, prog_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [4:0]        frac_reg, frac_next;
    nflags_t           flags_reg, flags_next;
    logic              bs_reg, bs_next;
    logic              halted_reg, halted_next;

    logic [4:0]        kind_reg [0:2];
    logic [4:0]        kind_next [0:2];
    logic [63:0]       val_reg [0:2];
    logic [63:0]       val_next [0:2];
    logic [7:0]        sbyte_reg, sbyte_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        idx_reg;
    logic              div_next;

    logic [63:0]       dq_reg, dq_next, jq_next;
    logic [3:0]        drem_reg, drem_next;
    logic [4:0]        dcnt_reg, jc_next;
    logic [2:0]        dstep_reg;
    logic              dneg_reg, jn_next;

    always_comb
    begin
        mode_t               m;
        logic [2:0]          p;
        logic [ACC_W-1:0]    a;
        logic [4:0]          fr;
        nflags_t             f;
        logic                bsl;
        logic                bad;
        logic                run_idle;
        logic                div;
        logic                tok;
        logic                hlt;
        logic [4:0]          rk [0:2];
        logic [63:0]         rv [0:2];
        logic [7:0]          rb;
        logic [1:0]          cnt;
        logic [63:0]         jq;
        logic [4:0]          jc;
        logic                jn;
        logic [3:0]          d;
        logic [ACC_W+3:0]    prod;
        logic [7:0]          b;
        logic [4:0]          ik;
        logic                is_dig;

        b        = in_data.in_byte;
        m        = mode_reg;
        p        = prog_reg;
        a        = acc_reg;
        fr       = frac_reg;
        f        = flags_reg;
        bsl      = bs_reg;
        hlt      = halted_reg;
        bad      = 1'b0;
        run_idle = 1'b0;
        div      = 1'b0;
        tok      = 1'b0;
        cnt      = 2'd0;
        rb       = 8'h00;
        jq       = 64'd0;
        jc       = 5'd0;
        jn       = 1'b0;
        ik       = K_UNION;
        d        = b[3:0];
        prod     = '0;
        is_dig   = (b >= 8'h30) && (b <= 8'h39);
        for (int i = 0; i < 3; i++)
        begin
            rk[i] = K_UNION;
            rv[i] = 64'd0;
        end

        if (halted_reg)
        begin
            hlt = !in_data.is_last;
        end
        else
        begin
            unique case (m)
                M_IDLE: run_idle = 1'b1;
                M_NULL, M_TRUE, M_FALSE:
                begin
                    if (b != kw_char(m, p))
                        bad = 1'b1;
                    else
                    begin
                        p = p + 3'd1;
                        if (p == kw_len(m))
                        begin
                            rk[cnt] = kw_kind(m);
                            cnt = cnt + 2'd1;
                            m = M_IDLE; p = '0; a = '0; fr = '0; f = '0; bsl = 1'b0;
                        end
                    end
                end
                M_WIDE:
                begin
                    if (p == 3'd1)
                    begin
                        if (b != 8'h88)
                            bad = 1'b1;
                        else
                            p = 3'd2;
                    end
                    else
                    begin
                        case (b)
                            8'hAA: begin rk[cnt] = K_UNION; tok = 1'b1; end
                            8'hA9: begin rk[cnt] = K_INTER; tok = 1'b1; end
                            8'h85: begin rk[cnt] = K_EMPTY; tok = 1'b1; end
                            default: bad = 1'b1;
                        endcase
                        if (tok)
                        begin
                            cnt = cnt + 2'd1;
                            tok = 1'b0;
                            m = M_IDLE; p = '0; a = '0; fr = '0; f = '0; bsl = 1'b0;
                        end
                    end
                end
                M_NUM:
                begin
                    if (f.zero)
                    begin
                        if (b != CH_DOT)
                            bad = 1'b1;
                        else
                        begin
                            f.zero = 1'b0;
                            f.dot  = 1'b1;
                        end
                    end
                    else if (b == CH_DOT)
                    begin
                        if (f.dot)
                            bad = 1'b1;
                        else
                            f.dot = 1'b1;
                    end
                    else if (is_dig)
                    begin
                        if (f.dot)
                        begin
                            if (fr >= 5'(MAX_FRAC_DIGITS))
                                bad = 1'b1;
                            else
                                fr = fr + 5'd1;
                        end
                        else if (!f.dig && d == 4'd0)
                            f.zero = 1'b1;
                        if (!bad)
                        begin
                            // a*10 + d must stay below 2^ACC_W
                            prod = ({4'b0, a} << 3) + ({4'b0, a} << 1) + (ACC_W+4)'(d);
                            if (prod[ACC_W+3:ACC_W] != 4'd0)
                                bad = 1'b1;
                            else
                            begin
                                a = prod[ACC_W-1:0];
                                f.dig = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (!f.dig || f.zero || (f.dot && fr == 5'd0))
                            bad = 1'b1;
                        else
                        begin
                            div = 1'b1;
                            jq  = 64'(a) << FRACTION_BITS;
                            jc  = fr;
                            jn  = f.neg;
                            rk[cnt] = K_NUMBER;
                            cnt = cnt + 2'd1;
                            m = M_IDLE; p = '0; a = '0; fr = '0; f = '0; bsl = 1'b0;
                            run_idle = 1'b1;
                        end
                    end
                end
                M_STR:
                begin
                    if (b == CH_QUOTE && !bsl)
                    begin
                        rk[cnt] = K_SEND;
                        cnt = cnt + 2'd1;
                        m = M_IDLE; p = '0; a = '0; fr = '0; f = '0; bsl = 1'b0;
                    end
                    else
                    begin
                        rk[cnt] = K_SBYTE;
                        rb = b;
                        cnt = cnt + 2'd1;
                        bsl = (b == CH_BSL);
                    end
                end
                default: bad = 1'b1;
            endcase

            if (run_idle && !bad)
            begin
                unique case (b) inside
                    8'h20, 8'h09, [8'h0A:8'h0D]: begin end
                    8'h7C: begin ik = K_UNION;  tok = 1'b1; end
                    8'h26: begin ik = K_INTER;  tok = 1'b1; end
                    8'h2E: begin ik = K_APPEND; tok = 1'b1; end
                    8'h2C: begin ik = K_COMMA;  tok = 1'b1; end
                    8'h5F: begin ik = K_EMPTY;  tok = 1'b1; end
                    8'h55: begin ik = K_UNIV;   tok = 1'b1; end
                    8'h2A: begin ik = K_WILD;   tok = 1'b1; end
                    8'h5B: begin ik = K_LBRACK; tok = 1'b1; end
                    8'h5D: begin ik = K_RBRACK; tok = 1'b1; end
                    8'h7B: begin ik = K_LBRACE; tok = 1'b1; end
                    8'h7D: begin ik = K_RBRACE; tok = 1'b1; end
                    8'h3A: begin ik = K_COLON;  tok = 1'b1; end
                    8'h28: begin ik = K_LPAREN; tok = 1'b1; end
                    8'h29: begin ik = K_RPAREN; tok = 1'b1; end
                    8'h21: begin ik = K_BANG;   tok = 1'b1; end
                    8'h6E: begin m = M_NULL;  p = 3'd1; end
                    8'h74: begin m = M_TRUE;  p = 3'd1; end
                    8'h66: begin m = M_FALSE; p = 3'd1; end
                    8'hE2: begin m = M_WIDE;  p = 3'd1; end
                    8'h2D:
                    begin
                        m = M_NUM;
                        f = '{zero: 1'b0, dig: 1'b0, dot: 1'b0, neg: 1'b1};
                    end
                    8'h22: begin m = M_STR; bsl = 1'b0; end
                    [8'h30:8'h39]:
                    begin
                        m = M_NUM;
                        f = '{zero: (d == 4'd0), dig: 1'b1, dot: 1'b0, neg: 1'b0};
                        a = ACC_W'(d);
                    end
                    default: bad = 1'b1;
                endcase
                if (tok)
                begin
                    rk[cnt] = ik;
                    cnt = cnt + 2'd1;
                end
            end

            if (!bad && in_data.is_last)
            begin
                if (m == M_NUM)
                begin
                    if (!f.dig || f.zero || (f.dot && fr == 5'd0))
                        bad = 1'b1;
                    else
                    begin
                        rk[cnt] = K_NUMBER;
                        if (!div)
                        begin
                            div = 1'b1;
                            jq  = 64'(a) << FRACTION_BITS;
                            jc  = fr;
                            jn  = f.neg;
                        end
                        else
                            rv[cnt] = f.neg ? -(64'(a) << FRACTION_BITS)
                                            : (64'(a) << FRACTION_BITS);
                        cnt = cnt + 2'd1;
                        m = M_IDLE; p = '0; a = '0; fr = '0; f = '0; bsl = 1'b0;
                    end
                end
                if (!bad && m != M_IDLE)
                    bad = 1'b1;
                if (!bad)
                begin
                    rk[cnt] = K_END;
                    cnt = cnt + 2'd1;
                    m = M_IDLE; p = '0; a = '0; fr = '0; f = '0; bsl = 1'b0;
                end
            end

            if (bad)
            begin
                rk[cnt] = K_ERROR;
                rv[cnt] = 64'd0;
                cnt = cnt + 2'd1;
                m = M_IDLE; p = '0; a = '0; fr = '0; f = '0; bsl = 1'b0;
                hlt = !in_data.is_last;
            end
        end

        mode_next   = m;
        prog_next   = p;
        acc_next    = a;
        frac_next   = fr;
        flags_next  = f;
        bs_next     = bsl;
        halted_next = hlt;
        for (int i = 0; i < 3; i++)
        begin
            kind_next[i] = rk[i];
            val_next[i]  = rv[i];
        end
        sbyte_next  = rb;
        cnt_next    = cnt;
        div_next    = div;
        jq_next     = jq;
        jc_next     = jc;
        jn_next     = jn;
    end

    // eight quotient bits of a divide by ten per cycle
    always_comb
    begin
        logic [3:0] r;
        logic [4:0] t;
        logic [63:0] q;
        r = drem_reg;
        q = dq_reg;
        for (int i = 0; i < 8; i++)
        begin
            t = {r, q[63]};
            q = {q[62:0], 1'b0};
            if (t >= 5'd10)
            begin
                q[0] = 1'b1;
                r = 4'(t - 5'd10);
            end
            else
                r = t[3:0];
        end
        dq_next   = q;
        drem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            prog_reg   <= '0;
            acc_reg    <= '0;
            frac_reg   <= '0;
            flags_reg  <= '0;
            bs_reg     <= 1'b0;
            halted_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            dcnt_reg   <= '0;
            dstep_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                mode_reg   <= mode_next;
                prog_reg   <= prog_next;
                acc_reg    <= acc_next;
                frac_reg   <= frac_next;
                flags_reg  <= flags_next;
                bs_reg     <= bs_next;
                halted_reg <= halted_next;
                cnt_reg    <= cnt_next;
                idx_reg    <= '0;
                dcnt_reg   <= div_next ? jc_next : 5'd0;
                dstep_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                dstep_reg <= dstep_reg + 3'd1;
                if (dstep_reg == 3'd7)
                    dcnt_reg <= dcnt_reg - 5'd1;
            end
            else if (cmd.send_adv)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_next;
            val_reg   <= val_next;
            sbyte_reg <= sbyte_next;
            dq_reg    <= jq_next;
            drem_reg  <= 4'd0;
            dneg_reg  <= jn_next;
        end
        else if (cmd.div_step)
        begin
            dq_reg   <= dq_next;
            drem_reg <= (dstep_reg == 3'd7) ? 4'd0 : drem_next;
        end
        else if (cmd.div_finish)
            val_reg[0] <= dneg_reg ? -dq_reg : dq_reg;
    end

    assign sts.plan_div  = div_next;
    assign sts.plan_any  = (cnt_next != 2'd0);
    assign sts.div_busy  = (dcnt_reg != 5'd0);
    assign sts.send_last = (idx_reg == cnt_reg - 2'd1);

    assign out_data.token_kind   = kind_reg[idx_reg];
    assign out_data.number_value = val_reg[idx_reg];
    assign out_data.string_byte  = (kind_reg[idx_reg] == K_SBYTE) ? sbyte_reg : 8'h00;
    assign out_data.last_of_run  = (idx_reg == cnt_reg - 2'd1);

endmodule

`default_nettype wire

### src/snt_ctrl.sv
// Lexer controller: accept, divide and send sequencing.
`default_nettype none

module snt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    output logic                   tok_valid,
    input  wire logic              tok_stall,
    input  wire snt_pkg::snt_sts_t sts,
    output snt_pkg::snt_cmd_t      cmd
);
    import snt_pkg::*;

    typedef enum logic [2:0] {
        ST_READY = 3'b001,
        ST_DIV   = 3'b010,
        ST_SEND  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign accept     = (state_reg == ST_READY) && byte_valid;
    assign byte_stall = (state_reg != ST_READY);
    assign tok_valid  = (state_reg == ST_SEND);

    assign cmd.load       = accept;
    assign cmd.div_step   = (state_reg == ST_DIV) && sts.div_busy;
    assign cmd.div_finish = (state_reg == ST_DIV) && !sts.div_busy;
    assign cmd.send_adv   = (state_reg == ST_SEND) && !tok_stall && !sts.send_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_READY:
            begin
                if (accept)
                begin
                    if (sts.plan_div)
                        state_next = ST_DIV;
                    else if (sts.plan_any)
                        state_next = ST_SEND;
                end
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!tok_stall && sts.send_last)
                    state_next = ST_READY;
            end
            default: state_next = ST_READY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_READY;
        else
            state_reg <= state_next;
    end

    a_div_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sts.plan_div |=> state_reg == ST_DIV)
        else $error("number finish did not enter divide");

    a_div_to_send: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && !sts.div_busy |=> state_reg == ST_SEND)
        else $error("divide end did not move to send");

    a_no_accept_while_send: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> byte_stall)
        else $error("input open while results pending");

endmodule

`default_nettype wire

### src/set_notation_token_lexer.sv
// Top level of the set-notation token lexer.
// A byte is taken only while the lexer is ready; its registered results then go out
// in order, held while tok_stall is high. A number with fraction digits passes first
// through the divide-by-ten unit. No new byte is taken until all results are sent.
// Reset: asynchronous, active low; the lexer returns to idle between tokens, not halted.
`default_nettype none

module set_notation_token_lexer #(
    parameter int FRACTION_BITS = snt_pkg::FRACTION_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_valid,
    output logic                  byte_stall,
    input  wire snt_pkg::tok_in_t byte_data,
    output logic                  tok_valid,
    input  wire logic             tok_stall,
    output snt_pkg::tok_out_t     tok_data
);
    import snt_pkg::*;

    snt_cmd_t cmd;
    snt_sts_t sts;

    snt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    snt_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (byte_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (tok_data)
    );

    a_error_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind == K_ERROR |-> tok_data.last_of_run)
        else $error("error token not last of run");

    a_byte_only_for_string: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind != K_SBYTE |-> tok_data.string_byte == 8'h00)
        else $error("string byte set on other token");

    a_value_only_for_number: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind != K_NUMBER |-> tok_data.number_value == 64'sd0)
        else $error("number value set on other token");

endmodule

`default_nettype wire
